[hw/rtl/qpn_pkg.sv]
// shared widths, types and helper functions for the quaternion product block
`timescale 1ns / 1ps
`default_nettype none
package qpn_pkg;

  // field and register widths
  localparam int DW        = 16;
  localparam int CW        = 29;
  localparam logic [CW-1:0] TOL_RESET = 29'd26844;

  // product component, Q6.28 signed
  localparam int PW        = 34;
  // squared magnitude radicand, units of 2^-56, padded to an even width
  localparam int NW        = 66;
  // square root: one result bit per stage
  localparam int SQ_STEPS  = NW / 2;
  localparam int RTW       = SQ_STEPS;
  localparam int SREMW     = RTW + 2;
  // divider: quotient bits and widths
  localparam int DIV_STEPS = 17;
  localparam int DVW       = RTW + 1;
  localparam int DNW       = PW + 15 - 1;
  localparam int QW        = 20;

  typedef logic signed [DW-1:0] comp_t;
  typedef logic signed [PW-1:0] prod_t;

  // the four product components of one request
  typedef logic [3:0][PW-1:0] prod_arr_t;

  // data that rides along the root and divide stages
  typedef struct packed {
    logic [3:0][PW-1:0] p;
    logic [3:0][DW-1:0] po;
    logic               pass;
    logic               degen;
  } pl_t;

  // magnitude of a product component
  function automatic logic [PW-1:0] mag(input prod_t v);
    logic [PW-1:0] r;
    begin
      r = v[PW-1] ? PW'(-v) : PW'(v);
      return r;
    end
  endfunction

  // apply sign and clamp to the signed 16-bit range
  function automatic comp_t sat_signed(input logic [QW-1:0] q, input logic neg);
    comp_t r;
    begin
      if (neg) begin
        if (q > QW'(32768)) r = comp_t'(-32768);
        else r = comp_t'(-$signed({1'b0, q}));
      end else begin
        if (q > QW'(32767)) r = comp_t'(32767);
        else r = comp_t'(q);
      end
      return r;
    end
  endfunction

  // round a Q6.28 component to Q2.14, ties away from zero, saturate
  function automatic comp_t round_q14(input prod_t v);
    logic [PW:0] s;
    begin
      s = {1'b0, mag(v)} + (PW + 1)'(1 << 13);
      return sat_signed(QW'(s >> 14), v[PW-1]);
    end
  endfunction

endpackage
`default_nettype wire

[hw/rtl/qpn_if.sv]
// request, result and configuration channels of the quaternion product block
`timescale 1ns / 1ps
`default_nettype none
interface qpn_in_if;
  logic valid;
  logic ready;
  logic signed [qpn_pkg::DW-1:0] r_w, r_x, r_y, r_z;
  logic signed [qpn_pkg::DW-1:0] s_w, s_x, s_y, s_z;
  modport source(output valid, r_w, r_x, r_y, r_z, s_w, s_x, s_y, s_z, input ready);
  modport sink(input valid, r_w, r_x, r_y, r_z, s_w, s_x, s_y, s_z, output ready);
endinterface

interface qpn_out_if;
  logic valid;
  logic ready;
  logic signed [qpn_pkg::DW-1:0] out_w, out_x, out_y, out_z;
  logic renormalised;
  logic degenerate;
  modport source(output valid, out_w, out_x, out_y, out_z, renormalised, degenerate,
                 input ready);
  modport sink(input valid, out_w, out_x, out_y, out_z, renormalised, degenerate,
               output ready);
endinterface

interface qpn_cfg_if;
  logic valid;
  logic ready;
  logic [qpn_pkg::CW-1:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface
`default_nettype wire

[hw/rtl/quaternion_product_normalised.sv]
// Hamilton product R*S of two Q2.14 quaternions, renormalised to unit length
// unless within tolerance or zero. One quaternion pair is taken every cycle
// unless the output stalls; it passes through the 33-stage square root of the
// squared magnitude and the 17-stage quotient pipeline. A stalled output freezes
// the whole pipeline, so in_chan.ready follows out_chan.ready while a result is
// held. The tolerance register may be written at any time the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_product_normalised (
  input  wire       clk,
  input  wire       rst_n,
  qpn_in_if.sink    in_chan,
  qpn_out_if.source out_chan,
  qpn_cfg_if.sink   cfg_chan
);

  localparam int SQ  = qpn_pkg::SQ_STEPS;
  localparam int DVS = qpn_pkg::DIV_STEPS;
  localparam int PW  = qpn_pkg::PW;
  localparam int NW  = qpn_pkg::NW;

  logic adv;
  logic [qpn_pkg::CW-1:0] tol_r;

  // tolerance register
  assign cfg_chan.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= qpn_pkg::TOL_RESET;
    end else if (cfg_chan.valid) begin
      tol_r <= cfg_chan.data;
    end
  end

  // whole pipeline moves unless a finished result is held and out_chan.ready is low
  logic out_v_r;
  assign adv = !out_v_r || out_chan.ready;
  assign in_chan.ready = adv;

  // stage 1: partial products and squares
  logic signed [qpn_pkg::DW-1:0] rv [4];
  logic signed [qpn_pkg::DW-1:0] sv [4];
  assign rv[0] = in_chan.r_w;
  assign rv[1] = in_chan.r_x;
  assign rv[2] = in_chan.r_y;
  assign rv[3] = in_chan.r_z;
  assign sv[0] = in_chan.s_w;
  assign sv[1] = in_chan.s_x;
  assign sv[2] = in_chan.s_y;
  assign sv[3] = in_chan.s_z;

  logic               v1_r;
  logic signed [31:0] mul_r [4][4];
  logic [30:0]        rsq_r [4];
  logic [30:0]        ssq_r [4];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          mul_r[i][j] <= 32'(sv[i] * rv[j]);
        end
        rsq_r[i] <= 31'(rv[i] * rv[i]);
        ssq_r[i] <= 31'(sv[i] * sv[i]);
      end
    end
  end

  // stage 2: product components and squared input norms
  logic                  v2_r;
  qpn_pkg::prod_arr_t    p2_r;
  logic [32:0]           nr_r, ns_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_r[0] <= PW'(mul_r[0][0]) - PW'(mul_r[1][1]) - PW'(mul_r[2][2]) - PW'(mul_r[3][3]);
      p2_r[1] <= PW'(mul_r[0][1]) + PW'(mul_r[1][0]) - PW'(mul_r[2][3]) + PW'(mul_r[3][2]);
      p2_r[2] <= PW'(mul_r[0][2]) + PW'(mul_r[1][3]) + PW'(mul_r[2][0]) - PW'(mul_r[3][1]);
      p2_r[3] <= PW'(mul_r[0][3]) - PW'(mul_r[1][2]) + PW'(mul_r[2][1]) + PW'(mul_r[3][0]);
      nr_r <= 33'(rsq_r[0]) + 33'(rsq_r[1]) + 33'(rsq_r[2]) + 33'(rsq_r[3]);
      ns_r <= 33'(ssq_r[0]) + 33'(ssq_r[1]) + 33'(ssq_r[2]) + 33'(ssq_r[3]);
    end
  end

  // stage 3: squared magnitude of the product
  logic                  v3_r;
  qpn_pkg::prod_arr_t    p3_r;
  logic [NW-1:0]         n_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      p3_r <= p2_r;
      n_r  <= NW'(nr_r) * NW'(ns_r);
    end
  end

  // stage 4: tolerance window, zero check and pass-through rounding
  localparam logic [NW-1:0] ONE_SQ = NW'(1) << 56;
  logic [NW-1:0] diff;
  logic [NW-1:0] tol_wide;
  assign diff     = (n_r >= ONE_SQ) ? (n_r - ONE_SQ) : (ONE_SQ - n_r);
  assign tol_wide = NW'({tol_r, 28'b0});

  logic                v_sq_r   [SQ+1];
  qpn_pkg::pl_t        pl_sq_r  [SQ+1];
  logic [NW-1:0]       rad_r    [SQ+1];
  logic [qpn_pkg::SREMW-1:0] srem_r [SQ+1];
  logic [qpn_pkg::RTW-1:0]   root_r [SQ+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        pl_sq_r[0].p[k]  <= p3_r[k];
        pl_sq_r[0].po[k] <= qpn_pkg::round_q14(qpn_pkg::prod_t'(p3_r[k]));
      end
      pl_sq_r[0].pass  <= diff < tol_wide;
      pl_sq_r[0].degen <= n_r == '0;
      rad_r[0]  <= n_r;
      srem_r[0] <= '0;
      root_r[0] <= '0;
    end
  end

  // square root: one root bit per stage
  for (genvar g = 0; g < SQ; g++) begin : g_sqrt
    logic [qpn_pkg::SREMW-1:0] rem2, trial;
    logic ge;
    assign rem2  = {srem_r[g][qpn_pkg::SREMW-3:0], rad_r[g][NW-1 -: 2]};
    assign trial = {root_r[g], 2'b01};
    assign ge    = rem2 >= trial;
    always_ff @(posedge clk) begin
      if (adv) begin
        pl_sq_r[g+1] <= pl_sq_r[g];
        rad_r[g+1]   <= {rad_r[g][NW-3:0], 2'b00};
        srem_r[g+1]  <= ge ? (rem2 - trial) : rem2;
        root_r[g+1]  <= {root_r[g][qpn_pkg::RTW-2:0], ge};
      end
    end
  end

  // divider setup: divisor 2m, dividend |p|*2^15 + m
  logic                   v_dv_r  [DVS+1];
  qpn_pkg::pl_t           pl_dv_r [DVS+1];
  logic [qpn_pkg::DVW-1:0] dvs_r  [DVS+1];
  logic [qpn_pkg::DVW-1:0] drem_r [DVS+1][4];
  logic [DVS-1:0]          dlow_r [DVS+1][4];
  logic [qpn_pkg::DNW-1:0] dnd    [4];

  for (genvar l = 0; l < 4; l++) begin : g_dnd
    assign dnd[l] = qpn_pkg::DNW'({qpn_pkg::mag(pl_sq_r[SQ].p[l]), 15'b0})
                  + qpn_pkg::DNW'(root_r[SQ]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pl_dv_r[0] <= pl_sq_r[SQ];
      dvs_r[0]   <= {root_r[SQ], 1'b0};
      for (int l = 0; l < 4; l++) begin
        drem_r[0][l] <= qpn_pkg::DVW'(dnd[l][qpn_pkg::DNW-1:DVS]);
        dlow_r[0][l] <= dnd[l][DVS-1:0];
      end
    end
  end

  // restoring divide: one quotient bit per stage on each lane
  for (genvar g = 0; g < DVS; g++) begin : g_div
    for (genvar l = 0; l < 4; l++) begin : g_lane
      logic [qpn_pkg::DVW:0] rem2;
      logic ge;
      assign rem2 = {drem_r[g][l], dlow_r[g][l][DVS-1]};
      assign ge   = rem2 >= {1'b0, dvs_r[g]};
      always_ff @(posedge clk) begin
        if (adv) begin
          drem_r[g+1][l] <= qpn_pkg::DVW'(ge ? (rem2 - {1'b0, dvs_r[g]}) : rem2);
          dlow_r[g+1][l] <= {dlow_r[g][l][DVS-2:0], ge};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        pl_dv_r[g+1] <= pl_dv_r[g];
        dvs_r[g+1]   <= dvs_r[g];
      end
    end
  end

  // output selection
  qpn_pkg::comp_t res [4];
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      if (pl_dv_r[DVS].degen) begin
        res[l] = '0;
      end else if (pl_dv_r[DVS].pass) begin
        res[l] = qpn_pkg::comp_t'(pl_dv_r[DVS].po[l]);
      end else begin
        res[l] = qpn_pkg::sat_signed(qpn_pkg::QW'(dlow_r[DVS][l]),
                                     pl_dv_r[DVS].p[l][PW-1]);
      end
    end
  end

  qpn_pkg::comp_t ow_r, ox_r, oy_r, oz_r;
  logic renorm_r, degen_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      ow_r     <= res[0];
      ox_r     <= res[1];
      oy_r     <= res[2];
      oz_r     <= res[3];
      renorm_r <= !pl_dv_r[DVS].pass && !pl_dv_r[DVS].degen;
      degen_r  <= pl_dv_r[DVS].degen;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      out_v_r <= 1'b0;
      for (int k = 0; k <= SQ; k++) v_sq_r[k] <= 1'b0;
      for (int k = 0; k <= DVS; k++) v_dv_r[k] <= 1'b0;
    end else if (adv) begin
      v1_r      <= in_chan.valid;
      v2_r      <= v1_r;
      v3_r      <= v2_r;
      v_sq_r[0] <= v3_r;
      for (int k = 1; k <= SQ; k++) v_sq_r[k] <= v_sq_r[k-1];
      v_dv_r[0] <= v_sq_r[SQ];
      for (int k = 1; k <= DVS; k++) v_dv_r[k] <= v_dv_r[k-1];
      out_v_r   <= v_dv_r[DVS];
    end
  end

  assign out_chan.valid        = out_v_r;
  assign out_chan.out_w        = ow_r;
  assign out_chan.out_x        = ox_r;
  assign out_chan.out_y        = oy_r;
  assign out_chan.out_z        = oz_r;
  assign out_chan.renormalised = renorm_r;
  assign out_chan.degenerate   = degen_r;

  // a zero magnitude gives zeros and no renormalisation
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && degen_r |-> ow_r == '0 && ox_r == '0 && oy_r == '0 && oz_r == '0
                           && !renorm_r)
    else $error("degenerate result is not zero");

  // a renormalised component never exceeds one in magnitude
  a_renorm_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && renorm_r |-> ow_r <= 16'sd16384 && ow_r >= -16'sd16384
                         && ox_r <= 16'sd16384 && ox_r >= -16'sd16384
                         && oy_r <= 16'sd16384 && oy_r >= -16'sd16384
                         && oz_r <= 16'sd16384 && oz_r >= -16'sd16384)
    else $error("renormalised component out of unit range");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_v_r)
    else $error("result valid after reset");

endmodule
`default_nettype wire
